/* hdl/tcw_pkg.sv */
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int ADDR_W = 13;
    localparam int EXT_W  = ADDR_W + 2;
    localparam int CELL_W = 16;
    localparam int CHAR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;

    localparam logic [CELL_W-1:0] ERASE_RESET = 16'h0720;
    localparam logic [CHAR_W-1:0] ATTR_RESET  = 8'h07;

    // configuration register indexes
    localparam logic CFG_ATTR  = 1'b0;
    localparam logic CFG_ERASE = 1'b1;

    // control bytes of a put
    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_PUT,
        S_COPY,
        S_ERASE,
        S_FILL,
        S_RESP
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

/* hdl/tcw_req_if.sv */
// Request channel: command, character and read address.
`timescale 1ns / 1ps

interface tcw_req_if
    import tcw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [CHAR_W-1:0] char_code;
    logic              end_of_write;
    logic [ADDR_W-1:0] read_cell;

    modport source (output valid, cmd, char_code, end_of_write, read_cell, input ready);
    modport sink   (input valid, cmd, char_code, end_of_write, read_cell, output ready);
endinterface

/* hdl/tcw_rsp_if.sv */
// Response channel: read data, cursor, display start and flags.
`timescale 1ns / 1ps

interface tcw_rsp_if
    import tcw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] cell_data;
    logic [ADDR_W-1:0] cursor_cell;
    logic [ADDR_W-1:0] screen_start;
    logic              cursor_update;
    logic              beep;

    modport source (output valid, cell_data, cursor_cell, screen_start, cursor_update, beep,
                    input ready);
    modport sink   (input valid, cell_data, cursor_cell, screen_start, cursor_update, beep,
                    output ready);
endinterface

/* hdl/tcw_cell_ram.sv */
// Video cell memory: one write port, one registered read port.
`timescale 1ns / 1ps

module tcw_cell_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH = 8192
) (
    input  logic              i_clk,
    input  t_mem_req          i_req,
    output logic [CELL_W-1:0] o_rdata
);
    localparam int AW = $clog2(DEPTH);

    logic [CELL_W-1:0] r_cells [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_cells[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_cells[i_req.raddr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/tcw_ctrl.sv */
// Console sequencer: cursor state, scroll/clear sweeps and response register.
`timescale 1ns / 1ps

module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int COLUMNS      = 80,
    parameter int ROWS         = 25,
    parameter int MEMORY_CELLS = 8192
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tcw_req_if.sink           i_req,
    tcw_rsp_if.source         o_rsp,
    input  logic [CHAR_W-1:0] i_attr,
    input  logic [CELL_W-1:0] i_erase,
    output t_mem_req          o_mem,
    input  logic [CELL_W-1:0] i_rdata
);
    localparam logic [COL_W-1:0]  COLS_C   = COL_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] COLS_LST = ADDR_W'(COLUMNS - 1);
    localparam logic [EXT_W-1:0]  COLS_E   = EXT_W'(COLUMNS);
    localparam logic [EXT_W-1:0]  SCREEN_E = EXT_W'(ROWS * COLUMNS);
    localparam logic [EXT_W-1:0]  MC_E     = EXT_W'(MEMORY_CELLS);
    localparam logic [ADDR_W-1:0] MC_LAST  = ADDR_W'(MEMORY_CELLS - 1);
    localparam logic [ROW_W:0]    ROWS_R   = (ROW_W + 1)'(ROWS);

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_start, n_start;
    logic [ADDR_W-1:0] r_cursor, n_cursor;
    logic [COL_W-1:0]  r_column, n_column;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_cp_valid, n_cp_valid;
    logic [ADDR_W-1:0] r_cp_dst, n_cp_dst;
    logic              r_cp_src_ok, n_cp_src_ok;
    logic              r_lf_done, n_lf_done;
    t_cmd              r_cmd, n_cmd;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_eow, n_eow;
    logic              r_rd_ok, n_rd_ok;
    logic              r_beep, n_beep;

    logic              r_out_valid;
    logic [CELL_W-1:0] r_out_data;
    logic [ADDR_W-1:0] r_out_cursor;
    logic [ADDR_W-1:0] r_out_start;
    logic              r_out_upd;
    logic              r_out_beep;

    logic              in_ready, accept, resp_free, finish, out_load;
    logic              is_print, wrap, lf_need, row_last, do_scroll, need_copy;
    logic              copy_issue, erase_last, fill_last;
    logic [ADDR_W-1:0] cur_a, cur_b, col_ext;
    logic [COL_W-1:0]  col_a;
    logic [ROW_W-1:0]  row_inc;
    logic [EXT_W-1:0]  copy_src, erase_addr, wr_addr;
    logic              wr_want, rd_en;
    logic [CELL_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [CELL_W-1:0] out_data;
    logic              out_upd;

    assign in_ready  = (r_state == S_IDLE);
    assign accept    = i_req.valid && in_ready;
    assign resp_free = !r_out_valid || o_rsp.ready;

    // put decode
    assign is_print = !((r_char == CH_NUL) || (r_char == CH_BEL) || (r_char == CH_BS)
                     || (r_char == CH_TAB) || (r_char == CH_LF) || (r_char == CH_VT)
                     || (r_char == CH_FF) || (r_char == CH_CR) || (r_char == CH_DEL));
    assign wrap      = is_print && !r_lf_done && (r_column >= COLS_C);
    assign lf_need   = !r_lf_done && ((r_char == CH_LF) || (r_char == CH_FF) || wrap);
    assign row_last  = ({1'b0, r_row} + (ROW_W + 1)'(1)) >= ROWS_R;
    assign do_scroll = lf_need && row_last;
    assign col_ext   = {{(ADDR_W - COL_W){1'b0}}, r_column};
    assign cur_a     = wrap ? (r_cursor - COLS_A) : r_cursor;
    assign col_a     = wrap ? (r_column - COLS_C) : r_column;
    assign cur_b     = (lf_need && !row_last) ? (cur_a + COLS_A) : cur_a;
    assign row_inc   = (lf_need && !row_last) ? (r_row + ROW_W'(1)) : r_row;

    assign need_copy  = ({2'b00, r_start} + SCREEN_E + COLS_E) >= MC_E;
    assign copy_src   = {2'b00, r_start} + {2'b00, r_idx};
    assign copy_issue = {2'b00, r_idx} < SCREEN_E;
    assign erase_addr = {2'b00, r_start} + SCREEN_E + {2'b00, r_idx};
    assign erase_last = (r_idx == COLS_LST);
    assign fill_last  = (r_idx == MC_LAST);

    assign finish   = (r_state == S_RESP) || ((r_state == S_PUT) && !do_scroll)
                   || ((r_state == S_FILL) && fill_last);
    assign out_load = finish && resp_free;

    always_comb begin : p_next_state
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (fill_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    case (t_cmd'(i_req.cmd))
                        CMD_PUT:   n_state = S_PUT;
                        CMD_CLEAR: n_state = S_FILL;
                        default:   n_state = S_RESP;
                    endcase
                end
            end
            S_PUT: begin
                if (do_scroll) n_state = need_copy ? S_COPY : S_ERASE;
                else           n_state = resp_free ? S_IDLE : S_RESP;
            end
            S_COPY: begin
                if (!copy_issue) n_state = S_ERASE;
            end
            S_ERASE: begin
                if (erase_last) n_state = S_PUT;
            end
            S_FILL: begin
                if (fill_last) n_state = resp_free ? S_IDLE : S_RESP;
            end
            S_RESP: begin
                if (resp_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin : p_datapath
        n_start     = r_start;
        n_cursor    = r_cursor;
        n_column    = r_column;
        n_row       = r_row;
        n_idx       = r_idx;
        n_cp_valid  = 1'b0;
        n_cp_dst    = r_cp_dst;
        n_cp_src_ok = r_cp_src_ok;
        n_lf_done   = r_lf_done;
        n_cmd       = r_cmd;
        n_char      = r_char;
        n_eow       = r_eow;
        n_rd_ok     = r_rd_ok;
        n_beep      = r_beep;
        wr_want     = 1'b0;
        wr_addr     = {2'b00, r_cursor};
        wr_data     = i_erase;
        rd_en       = 1'b0;
        rd_addr     = i_req.read_cell;
        case (r_state)
            S_INIT, S_FILL: begin
                wr_want = 1'b1;
                wr_addr = {2'b00, r_idx};
                wr_data = (r_state == S_INIT) ? ERASE_RESET : i_erase;
                n_idx   = fill_last ? '0 : (r_idx + ADDR_W'(1));
            end
            S_IDLE: begin
                if (accept) begin
                    n_cmd     = t_cmd'(i_req.cmd);
                    n_char    = i_req.char_code;
                    n_eow     = i_req.end_of_write;
                    n_rd_ok   = {2'b00, i_req.read_cell} < MC_E;
                    n_beep    = 1'b0;
                    n_lf_done = 1'b0;
                    n_idx     = '0;
                    rd_en     = (t_cmd'(i_req.cmd) == CMD_READ);
                    if (t_cmd'(i_req.cmd) == CMD_CLEAR) begin
                        n_start  = '0;
                        n_cursor = '0;
                        n_column = '0;
                        n_row    = '0;
                    end
                end
            end
            S_PUT: begin
                if (do_scroll) begin
                    // wrap adjustment is kept; the put resumes after the scroll
                    n_cursor = cur_a;
                    n_column = col_a;
                    n_idx    = '0;
                end else begin
                    n_lf_done = 1'b0;
                    case (r_char)
                        CH_NUL, CH_TAB, CH_VT: begin
                        end
                        CH_BEL: n_beep = 1'b1;
                        CH_BS: begin
                            if (r_column != '0) begin
                                n_column = r_column - COL_W'(1);
                                n_cursor = r_cursor - ADDR_W'(1);
                                wr_want  = 1'b1;
                                wr_addr  = {2'b00, n_cursor};
                            end
                        end
                        CH_LF: begin
                            n_cursor = cur_b - col_ext;
                            n_column = '0;
                            n_row    = row_inc;
                        end
                        CH_FF: begin
                            n_cursor = cur_b;
                            n_row    = row_inc;
                        end
                        CH_CR: begin
                            n_cursor = r_cursor - col_ext;
                            n_column = '0;
                        end
                        CH_DEL: wr_want = 1'b1;
                        default: begin
                            wr_want  = 1'b1;
                            wr_addr  = {2'b00, cur_b};
                            wr_data  = {i_attr, r_char};
                            n_cursor = cur_b + ADDR_W'(1);
                            n_column = col_a + COL_W'(1);
                            n_row    = row_inc;
                        end
                    endcase
                end
            end
            S_COPY: begin
                // read cell start+i while writing cell i-1 with last cycle's data;
                // the source always sits above the destination
                rd_en       = copy_issue;
                rd_addr     = copy_src[ADDR_W-1:0];
                n_cp_src_ok = copy_src < MC_E;
                n_cp_dst    = r_idx;
                n_cp_valid  = copy_issue;
                wr_want     = r_cp_valid;
                wr_addr     = {2'b00, r_cp_dst};
                wr_data     = r_cp_src_ok ? i_rdata : '0;
                if (copy_issue) begin
                    n_idx = r_idx + ADDR_W'(1);
                end else begin
                    n_cursor = r_cursor - r_start;
                    n_start  = '0;
                    n_idx    = '0;
                end
            end
            S_ERASE: begin
                wr_want = 1'b1;
                wr_addr = erase_addr;
                if (erase_last) begin
                    n_start   = r_start + COLS_A;
                    n_cursor  = r_cursor + COLS_A;
                    n_lf_done = 1'b1;
                    n_idx     = '0;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    assign o_mem.we    = wr_want && (wr_addr < MC_E);
    assign o_mem.waddr = wr_addr[ADDR_W-1:0];
    assign o_mem.wdata = wr_data;
    assign o_mem.re    = rd_en;
    assign o_mem.raddr = rd_addr;

    always_comb begin : p_response
        out_data = ((r_cmd == CMD_READ) && r_rd_ok) ? i_rdata : '0;
        case (r_cmd)
            CMD_PUT:   out_upd = r_eow;
            CMD_CLEAR: out_upd = 1'b1;
            default:   out_upd = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_start    <= '0;
            r_cursor   <= '0;
            r_column   <= '0;
            r_row      <= '0;
            r_idx      <= '0;
            r_cp_valid <= 1'b0;
            r_lf_done  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_start    <= n_start;
            r_cursor   <= n_cursor;
            r_column   <= n_column;
            r_row      <= n_row;
            r_idx      <= n_idx;
            r_cp_valid <= n_cp_valid;
            r_lf_done  <= n_lf_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_dst    <= n_cp_dst;
        r_cp_src_ok <= n_cp_src_ok;
        r_cmd       <= n_cmd;
        r_char      <= n_char;
        r_eow       <= n_eow;
        r_rd_ok     <= n_rd_ok;
        r_beep      <= n_beep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data   <= out_data;
            r_out_cursor <= n_cursor;
            r_out_start  <= n_start;
            r_out_upd    <= out_upd;
            r_out_beep   <= n_beep;
        end
    end

    assign i_req.ready         = in_ready;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.cell_data     = r_out_data;
    assign o_rsp.cursor_cell   = r_out_cursor;
    assign o_rsp.screen_start  = r_out_start;
    assign o_rsp.cursor_update = r_out_upd;
    assign o_rsp.beep          = r_out_beep;

`ifndef SYNTHESIS
    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready |-> !o_mem.we)
        else $error("cell write while waiting for a request");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !in_ready)
        else $error("request taken while another is in flight");

    a_position_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_column <= COLS_C) && ({1'b0, r_row} < ROWS_R))
        else $error("column or row out of range");

    a_copy_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_COPY) && o_mem.we && o_mem.re) |-> (o_mem.waddr < o_mem.raddr))
        else $error("screen copy overwrote a cell before reading it");
`endif

endmodule

/* hdl/text_console_writer_unit.sv */
// Top level: configuration registers, console sequencer and video cell memory.
// A put, a read or an unknown command goes to S_PUT or S_RESP, then loads the response register
// once it is free; no new request is taken until the last one is done. A line feed, form feed or
// wrap on the last row adds a scroll: the screen is first copied to cell 0 when the window would
// leave memory, then the new row is erased and the put resumes. A clear fills every cell, holding
// the input. Reset: synchronous, active low; a fill of every cell follows, no request taken.
`timescale 1ns / 1ps

module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS      = 80,
    parameter int ROWS         = 25,
    parameter int MEMORY_CELLS = 8192
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tcw_req_if.sink           i_req,
    tcw_rsp_if.source         o_rsp,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CELL_W-1:0] i_cfg_wdata
);
    logic [CHAR_W-1:0] r_attr;
    logic [CELL_W-1:0] r_erase;
    t_mem_req          mem_req;
    logic [CELL_W-1:0] mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr  <= ATTR_RESET;
            r_erase <= ERASE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ATTR:  r_attr  <= i_cfg_wdata[CHAR_W-1:0];
                CFG_ERASE: r_erase <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    tcw_ctrl #(
        .COLUMNS      (COLUMNS),
        .ROWS         (ROWS),
        .MEMORY_CELLS (MEMORY_CELLS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_attr  (r_attr),
        .i_erase (r_erase),
        .o_mem   (mem_req),
        .i_rdata (mem_rdata)
    );

    tcw_cell_ram #(
        .DEPTH (MEMORY_CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule
